>>> src/assert_macros.svh
// Shared assertion macros; every macro asserts on clk with arst_n low disabling.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/b64e_pkg.sv
package b64e_pkg;

	localparam int CountWidthDef = 16;
	localparam int LimitWidth = 16;
	localparam int PaddrWidth = 2;
	localparam int PdataWidth = 32;

	localparam logic [PaddrWidth-1:0] ADDR_OUT_LIMIT = 2'd0;
	localparam logic [LimitWidth-1:0] OUT_LIMIT_RESET = 16'hFFFF;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_char;
		logic        end_of_run;
		logic        end_of_message;
		logic        limit_hit;
		logic [15:0] chars_so_far;
	} out_item_t;

	// Characters formed from one input byte, emitted in order up to last_idx.
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [1:0]      last_idx;
		logic            last;
	} job_t;

	// Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		priority if (v < 6'd26) begin
			return w + 8'h41;
		end else if (v < 6'd52) begin
			return w + 8'h47;
		end else if (v < 6'd62) begin
			return w - 8'h04;
		end else if (v == 6'd62) begin
			return 8'h2B;
		end else begin
			return 8'h2F;
		end
	endfunction

endpackage

>>> src/b64e_in_if.sv
interface b64e_in_if import b64e_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

>>> src/b64e_out_if.sv
interface b64e_out_if import b64e_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

>>> src/base64_stream_encoder_top.sv
// Streaming base64 encoder, standard alphabet with '=' padding.
// raw: one transfer per source byte (in_byte, last_byte marks message end).
// enc: one transfer per output character with end_of_run, end_of_message,
//   limit_hit and the running character count chars_so_far.
// APB port: register 0 (byte address 0) is out_limit, the most characters
//   one message may produce; reset value 65535. Write only while idle.
// The first character of a byte goes from raw through the job register and
//   then the output register to enc.
// Throughput: a byte produces one to four characters, and the single output
//   register passes one character per cycle while enc is ready; a long
//   message gives four characters per three bytes. Bytes that arrive after
//   the limit stops output are dropped whole without producing characters.
// The next byte is taken as the last character of the current one is loaded
//   into the output register.
// Reset clears the group phase, carry bits, count and stop flag; out_limit
//   returns to 65535. When enc is stalled the output register holds its
//   character and raw backs up after one buffered byte.
module base64_stream_encoder_top import b64e_pkg::*; #(
	parameter int COUNT_WIDTH = CountWidthDef
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PaddrWidth-1:0] paddr,
	input  logic [PdataWidth-1:0] pwdata,
	output logic [PdataWidth-1:0] prdata,
	output logic                  pready,
	b64e_in_if.sink               raw,
	b64e_out_if.source            enc
);

	logic [LimitWidth-1:0] out_limit;
	logic                  job_valid;
	logic                  job_done;
	job_t                  job;

	b64e_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.out_limit (out_limit)
	);

	b64e_group u_group (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw       (raw),
		.job_done  (job_done),
		.job_valid (job_valid),
		.job       (job)
	);

	b64e_emit #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.out_limit (out_limit),
		.job_valid (job_valid),
		.job       (job),
		.job_done  (job_done),
		.enc       (enc)
	);

endmodule

>>> src/b64e_cfg.sv
module b64e_cfg import b64e_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PaddrWidth-1:0] paddr,
	input  logic [PdataWidth-1:0] pwdata,
	output logic [PdataWidth-1:0] prdata,
	output logic                  pready,
	output logic [LimitWidth-1:0] out_limit
);

	logic [LimitWidth-1:0] limit_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= OUT_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_OUT_LIMIT) begin
			limit_q <= pwdata[LimitWidth-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_OUT_LIMIT) begin
			prdata = PdataWidth'(limit_q);
		end
	end

	assign out_limit = limit_q;

endmodule

>>> src/b64e_group.sv
module b64e_group import b64e_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	b64e_in_if.sink raw,
	input  logic job_done,
	output logic job_valid,
	output job_t job
);

	logic [1:0] phase_q;
	logic [3:0] carry_q;
	logic       valid_s1;
	job_t       job_s1;
	job_t       job_d;
	logic [1:0] phase_d;
	logic [3:0] carry_d;
	logic [7:0] b;
	logic       take;

	assign raw.ready = !valid_s1 || job_done;
	assign take = raw.valid && raw.ready;
	assign b = raw.item.in_byte;

	always_comb begin
		job_d.chars = {4{PAD_CHAR}};
		job_d.last = raw.item.last_byte;
		unique case (phase_q)
			2'd0: begin
				job_d.chars[0] = b64_char(b[7:2]);
				carry_d = {2'b00, b[1:0]};
				phase_d = 2'd1;
				job_d.last_idx = 2'd0;
				if (raw.item.last_byte) begin
					job_d.chars[1] = b64_char({b[1:0], 4'b0000});
					job_d.last_idx = 2'd3;
				end
			end
			2'd1: begin
				job_d.chars[0] = b64_char({carry_q[1:0], b[7:4]});
				carry_d = b[3:0];
				phase_d = 2'd2;
				job_d.last_idx = 2'd0;
				if (raw.item.last_byte) begin
					job_d.chars[1] = b64_char({b[3:0], 2'b00});
					job_d.last_idx = 2'd2;
				end
			end
			default: begin
				job_d.chars[0] = b64_char({carry_q, b[7:6]});
				job_d.chars[1] = b64_char(b[5:0]);
				carry_d = 4'd0;
				phase_d = 2'd0;
				job_d.last_idx = 2'd1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 2'd0;
			carry_q  <= 4'd0;
			valid_s1 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
				if (raw.item.last_byte) begin
					phase_q <= 2'd0;
					carry_q <= 4'd0;
				end else begin
					phase_q <= phase_d;
					carry_q <= carry_d;
				end
			end else if (job_done) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_s1 <= job_d;
		end
	end

	assign job_valid = valid_s1;
	assign job = job_s1;

endmodule

>>> src/b64e_emit.sv
`include "assert_macros.svh"

module b64e_emit import b64e_pkg::*; #(
	parameter int COUNT_WIDTH = CountWidthDef
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [LimitWidth-1:0] out_limit,
	input  logic                  job_valid,
	input  job_t                  job,
	output logic                  job_done,
	b64e_out_if.source enc
);

	localparam int WideWidth = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
	localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

	logic [1:0]             k_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   stopped_q;
	logic                   out_valid_q;
	out_item_t              out_q;

	logic [COUNT_WIDTH-1:0] next_count;
	logic [WideWidth-1:0]   count_w;
	logic [WideWidth-1:0]   next_w;
	logic [WideWidth-1:0]   limit_w;
	logic                   out_free;
	logic                   blocked;
	logic                   emit;
	logic                   hit;
	logic                   run_end;

	assign next_count = count_q + 1'b1;
	assign count_w = WideWidth'(count_q);
	assign next_w = WideWidth'(next_count);
	assign limit_w = WideWidth'(out_limit);

	assign out_free = !out_valid_q || enc.ready;
	assign blocked = stopped_q || (count_w >= limit_w);
	assign emit = job_valid && !blocked && out_free;
	assign hit = (next_w >= limit_w) || (next_count == CountMax);
	assign run_end = (k_q == job.last_idx) || hit;
	// a blocked job is dropped whole, no output slot needed
	assign job_done = job_valid && (blocked || (out_free && run_end));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= 2'd0;
			count_q     <= '0;
			stopped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_done) begin
				k_q <= 2'd0;
			end else if (emit) begin
				k_q <= k_q + 2'd1;
			end

			if (job_done && job.last) begin
				count_q   <= '0;
				stopped_q <= 1'b0;
			end else if (emit) begin
				count_q   <= next_count;
				stopped_q <= hit;
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (enc.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_char       <= job.chars[k_q];
			out_q.end_of_run     <= run_end;
			out_q.end_of_message <= run_end && job.last;
			out_q.limit_hit      <= hit;
			out_q.chars_so_far   <= next_w[15:0];
		end
	end

	assign enc.valid = out_valid_q;
	assign enc.item = out_q;

	`ASSERT_ALWAYS(a_hit_ends_run, !(out_valid_q && out_q.limit_hit) || out_q.end_of_run,
		"limit_hit without end_of_run")
	`ASSERT_ALWAYS(a_index_in_job, !job_valid || (k_q <= job.last_idx),
		"character index beyond job")
	`ASSERT_NEXT(a_msg_clears, job_done && job.last, count_q == '0 && !stopped_q,
		"message end did not clear count")

endmodule
